[sv/dphc_pkg.sv]
// Package for the delimited packet header checker.
// Holds the item, result and register types, character constants and match helpers.
// No dependencies.
package dphc_pkg;

	localparam int ID_CHARS_DEF = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [7:0] SEP_CHAR = 8'h7C;
	localparam logic [2:0] PAYLOAD_FIELD = 3'd5;
	localparam logic [3:0] POS_MAX = 4'd15;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [15:0] MAX_LENGTH_RST = 16'd256;
	localparam logic [3:0] PREFIX_LEN = 4'd4;
	localparam logic [3:0] ALL_LEN = 4'd3;

	localparam logic [2:0] FIELD_PREFIX = 3'd0;
	localparam logic [2:0] FIELD_VERSION = 3'd1;
	localparam logic [2:0] FIELD_TYPE = 3'd2;
	localparam logic [2:0] FIELD_TARGET = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_LENGTH = 3'd0,
		REG_VERSION_TEXT = 3'd1,
		REG_VERSION_LENGTH = 3'd2,
		REG_DEVICE_TEXT = 3'd3,
		REG_DEVICE_LENGTH = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} item_t;

	typedef struct packed {
		logic [2:0] field_index;
		logic [7:0] out_byte;
		logic is_separator;
		logic end_of_packet;
		logic packet_valid;
		logic for_this_device;
	} result_t;

	typedef struct packed {
		logic [15:0] max_length;
		logic [63:0] version_text;
		logic [3:0] version_length;
		logic [63:0] device_text;
		logic [3:0] device_length;
	} cfg_t;

	function automatic logic [7:0] prefix_char(input logic [1:0] pos);
		logic [7:0] ch;
		case (pos)
			2'd0: ch = 8'h48;
			2'd1: ch = 8'h55;
			2'd2: ch = 8'h4E;
			default: ch = 8'h54;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] all_char(input logic [1:0] pos);
		logic [7:0] ch;
		case (pos)
			2'd0: ch = 8'h41;
			default: ch = 8'h4C;
		endcase
		return ch;
	endfunction

	function automatic logic text_char_eq(input logic [63:0] text, input logic [3:0] len,
			input logic [3:0] pos, input logic [7:0] ch, input logic [3:0] lim);
		logic ok;
		ok = (len <= lim) && (pos < lim) && (pos < len) && (text[{pos[2:0], 3'b000} +: 8] == ch);
		return ok;
	endfunction

	function automatic logic text_len_ok(input logic [3:0] len, input logic [3:0] pos,
			input logic [3:0] lim);
		return (len <= lim) && (pos == len);
	endfunction

endpackage

[sv/dphc_cfg.sv]
// Configuration register file of the delimited packet header checker.
// Depends on dphc_pkg for the register index codes and the register struct.
module dphc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dphc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data,
	output dphc_pkg::cfg_t                 cfg
);
	import dphc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_length <= MAX_LENGTH_RST;
			cfg_q.version_text <= '0;
			cfg_q.version_length <= '0;
			cfg_q.device_text <= '0;
			cfg_q.device_length <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_LENGTH: cfg_q.max_length <= cfg_data[15:0];
				REG_VERSION_TEXT: cfg_q.version_text <= cfg_data;
				REG_VERSION_LENGTH: cfg_q.version_length <= cfg_data[3:0];
				REG_DEVICE_TEXT: cfg_q.device_text <= cfg_data;
				REG_DEVICE_LENGTH: cfg_q.device_length <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

[sv/dphc_parse.sv]
// Per-packet parser state and per-byte result logic of the header checker.
// Depends on dphc_pkg for item, result and register types and match helpers.
module dphc_parse #(
	parameter int ID_CHARS = dphc_pkg::ID_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  dphc_pkg::item_t   item,
	input  dphc_pkg::cfg_t    cfg,
	output dphc_pkg::result_t result
);
	import dphc_pkg::*;

	localparam logic [3:0] ID_LIM = 4'(ID_CHARS);

	logic [2:0] field_q, field_n;
	logic [3:0] pos_q, pos_n;
	logic [15:0] count_q, count_n, count_inc;
	logic too_long_q, too_long_n;
	logic prefix_q, prefix_n;
	logic version_q, version_n;
	logic [2:0] nonempty_q, nonempty_n;
	logic all_q, all_n;
	logic id_q, id_n;
	logic sep, in_header, last, valid;
	logic [7:0] ch;

	always_comb begin
		ch = item.data_byte;
		last = item.last_byte;
		in_header = field_q < PAYLOAD_FIELD;
		sep = (ch == SEP_CHAR) && in_header;

		count_inc = count_q + 16'd1;
		field_n = field_q;
		pos_n = pos_q;
		count_n = count_q;
		too_long_n = too_long_q;
		prefix_n = prefix_q;
		version_n = version_q;
		nonempty_n = nonempty_q;
		all_n = all_q;
		id_n = id_q;

		if (count_q == COUNT_MAX) begin
			too_long_n = 1'b1;
		end else begin
			count_n = count_inc;
			if (count_inc > cfg.max_length) too_long_n = 1'b1;
		end

		if (sep) begin
			if (field_q == FIELD_PREFIX && pos_q != PREFIX_LEN) prefix_n = 1'b0;
			if (field_q == FIELD_VERSION && !text_len_ok(cfg.version_length, pos_q, ID_LIM))
				version_n = 1'b0;
			if (field_q == FIELD_TARGET) begin
				if (pos_q != ALL_LEN) all_n = 1'b0;
				if (!text_len_ok(cfg.device_length, pos_q, ID_LIM)) id_n = 1'b0;
			end
			field_n = field_q + 3'd1;
			pos_n = '0;
		end else if (in_header) begin
			if (field_q == FIELD_PREFIX && (pos_q >= PREFIX_LEN || prefix_char(pos_q[1:0]) != ch))
				prefix_n = 1'b0;
			if (field_q == FIELD_VERSION &&
					!text_char_eq(cfg.version_text, cfg.version_length, pos_q, ch, ID_LIM))
				version_n = 1'b0;
			if (field_q >= FIELD_TYPE) nonempty_n[2'(field_q - FIELD_TYPE)] = 1'b1;
			if (field_q == FIELD_TARGET) begin
				if (pos_q >= ALL_LEN || all_char(pos_q[1:0]) != ch) all_n = 1'b0;
				if (!text_char_eq(cfg.device_text, cfg.device_length, pos_q, ch, ID_LIM))
					id_n = 1'b0;
			end
			if (pos_q < POS_MAX) pos_n = pos_q + 4'd1;
		end

		valid = last && !too_long_n && prefix_n && field_n == PAYLOAD_FIELD && version_n &&
			nonempty_n == 3'b111;

		result.field_index = field_q;
		result.out_byte = ch;
		result.is_separator = sep;
		result.end_of_packet = last;
		result.packet_valid = valid;
		result.for_this_device = valid && (all_n || id_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= '0;
			pos_q <= '0;
			count_q <= '0;
			too_long_q <= 1'b0;
			prefix_q <= 1'b1;
			version_q <= 1'b1;
			nonempty_q <= '0;
			all_q <= 1'b1;
			id_q <= 1'b1;
		end else if (step) begin
			if (last) begin
				field_q <= '0;
				pos_q <= '0;
				count_q <= '0;
				too_long_q <= 1'b0;
				prefix_q <= 1'b1;
				version_q <= 1'b1;
				nonempty_q <= '0;
				all_q <= 1'b1;
				id_q <= 1'b1;
			end else begin
				field_q <= field_n;
				pos_q <= pos_n;
				count_q <= count_n;
				too_long_q <= too_long_n;
				prefix_q <= prefix_n;
				version_q <= version_n;
				nonempty_q <= nonempty_n;
				all_q <= all_n;
				id_q <= id_n;
			end
		end
	end

endmodule

[sv/delimited_packet_header_checker_core.sv]
// Delimited packet header checker, top level.
// An accepted byte passes the input register and then the result register before its result is output.
// Throughput: one byte per cycle while result_stall is low; the per-byte parser update sets this figure.
// Reset clears the parser state, both stage valids and loads register defaults.
// Depends on dphc_pkg, dphc_cfg and dphc_parse.
module delimited_packet_header_checker_core #(
	parameter int ID_CHARS = dphc_pkg::ID_CHARS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  dphc_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output dphc_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dphc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data
);
	import dphc_pkg::*;

	cfg_t cfg;
	item_t item_s1;
	logic valid_s1;
	result_t result_s2, result_n;
	logic valid_s2;
	logic adv_s2, adv_s1;

	dphc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	dphc_parse #(.ID_CHARS(ID_CHARS)) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv_s1),
		.item(item_s1),
		.cfg(cfg),
		.result(result_n)
	);

	assign adv_s2 = !(valid_s2 && result_stall);
	assign adv_s1 = valid_s1 && adv_s2;
	assign item_stall = valid_s1 && !adv_s2;
	assign result_valid = valid_s2;
	assign result = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!item_stall) valid_s1 <= item_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) item_s1 <= item;
		if (adv_s1) result_s2 <= result_n;
	end

endmodule
